// File: hw/rtl/glyph_text_renderer_macros.svh
// Assertion macros used by the glyph text renderer checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef GLYPH_TEXT_RENDERER_MACROS_SVH
`define GLYPH_TEXT_RENDERER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define GTR_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that, when seen, forces another condition in the next cycle.
`define GTR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/gtr_pkg.sv
// Shared types and constants for the glyph text renderer.
// Used by every module of the block; depends on nothing else.
package gtr_pkg;

    localparam int GLYPH_SIZE  = 8;
    localparam int GLYPH_BITS  = GLYPH_SIZE * GLYPH_SIZE;
    localparam int LINE_PITCH  = 10;
    localparam int COORD_W     = 12;
    localparam int CURSOR_W    = 13;
    localparam int SCREEN_W    = 14;
    localparam int INDEX_W     = 24;
    localparam int COLOR_W     = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WIN_X    = 3'd0,
        REG_WIN_Y    = 3'd1,
        REG_WIN_W    = 3'd2,
        REG_WIN_H    = 3'd3,
        REG_SCR_COLS = 3'd4,
        REG_SCR_ROWS = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [COORD_W-1:0]  win_x;
        logic [COORD_W-1:0]  win_y;
        logic [CURSOR_W-1:0] win_w;
        logic [CURSOR_W-1:0] win_h;
        logic [CURSOR_W-1:0] scr_cols;
        logic [CURSOR_W-1:0] scr_rows;
    } cfg_t;

    typedef struct packed {
        logic [7:0]            char_code;
        logic [GLYPH_BITS-1:0] glyph_bits;
        logic                  first_of_string;
        logic [COORD_W-1:0]    start_col;
        logic [COORD_W-1:0]    start_row;
        logic [COLOR_W-1:0]    ink_color;
    } char_item_t;

    typedef struct packed {
        logic [INDEX_W-1:0] pixel_index;
        logic [COLOR_W-1:0] pixel_value;
        logic               last_pixel;
    } pix_item_t;

    // One character's drawing job: visible pixel mask, ink color and glyph origin on screen.
    typedef struct packed {
        logic [GLYPH_BITS-1:0] mask;
        logic [COLOR_W-1:0]    color;
        logic [SCREEN_W-1:0]   sx0;
        logic [SCREEN_W-1:0]   sy0;
    } job_t;

endpackage

// File: hw/rtl/gtr_front.sv
// Front end of the glyph text renderer: accepts characters, keeps the cursor,
// and turns each glyph into a clipped pixel mask. Depends on gtr_pkg.
module gtr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  gtr_pkg::cfg_t      cfg,
    input  logic               char_valid,
    output logic               char_ready,
    input  gtr_pkg::char_item_t char_item,
    input  logic               q_full,
    output logic               push,
    output gtr_pkg::job_t      push_job
);

    localparam int CW = gtr_pkg::CURSOR_W;
    localparam int SW = gtr_pkg::SCREEN_W;
    localparam int GS = gtr_pkg::GLYPH_SIZE;

    logic [CW-1:0]  col_reg, col_next;
    logic [CW-1:0]  row_reg, row_next;
    logic [gtr_pkg::COORD_W-1:0] home_reg, home_next;
    logic           halted_reg, halted_next;

    logic [CW-1:0]  col_cur, row_cur;
    logic           drop;
    logic           accept;
    logic [SW-1:0]  sx0, sy0, win_right, win_bottom;
    logic [SW-1:0]  px [GS];
    logic [SW-1:0]  py [GS];
    logic [GS-1:0]  col_ok, row_ok;
    logic [gtr_pkg::GLYPH_BITS-1:0] mask;
    logic [SW-1:0]  col_adv;
    logic [CW-1:0]  row_step;

    assign char_ready = !q_full;
    assign accept     = char_valid && char_ready;

    always_comb
    begin
        col_cur   = char_item.first_of_string ? CW'(char_item.start_col) : col_reg;
        row_cur   = char_item.first_of_string ? CW'(char_item.start_row) : row_reg;
        home_next = char_item.first_of_string ? char_item.start_col : home_reg;
        drop      = !char_item.first_of_string && halted_reg;

        sx0        = SW'(cfg.win_x) + SW'(col_cur);
        sy0        = SW'(cfg.win_y) + SW'(row_cur);
        win_right  = SW'(cfg.win_x) + SW'(cfg.win_w);
        win_bottom = SW'(cfg.win_y) + SW'(cfg.win_h);

        for (int i = 0; i < GS; i++)
        begin
            px[i]     = sx0 + SW'(i);
            py[i]     = sy0 + SW'(i);
            col_ok[i] = (px[i] < win_right) && (px[i] < SW'(cfg.scr_cols));
            row_ok[i] = (py[i] < win_bottom) && (py[i] < SW'(cfg.scr_rows));
        end

        // Glyph row dy sits in the byte at the top minus dy; bit 7 is leftmost.
        for (int dy = 0; dy < GS; dy++)
        begin
            for (int dx = 0; dx < GS; dx++)
            begin
                mask[gtr_pkg::GLYPH_BITS-1-GS*dy-dx] =
                    char_item.glyph_bits[gtr_pkg::GLYPH_BITS-1-GS*dy-dx]
                    && row_ok[dy] && col_ok[dx];
            end
        end

        // Cursor advance: newline or wrap both return to the home column.
        row_step = row_cur + CW'(gtr_pkg::LINE_PITCH);
        col_adv  = SW'(col_cur) + SW'(GS);
        if (char_item.char_code == gtr_pkg::NEWLINE_CODE)
        begin
            col_next = CW'(home_next);
            row_next = row_step;
        end
        else if (col_adv + SW'(GS) >= SW'(cfg.win_w))
        begin
            col_next = CW'(home_next);
            row_next = row_step;
        end
        else
        begin
            col_next = col_adv[CW-1:0];
            row_next = row_cur;
        end
        halted_next = (SW'(row_next) + SW'(GS)) >= SW'(cfg.win_h);
    end

    assign push           = accept && !drop && (|mask);
    assign push_job.mask  = mask;
    assign push_job.color = char_item.ink_color;
    assign push_job.sx0   = sx0;
    assign push_job.sy0   = sy0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg    <= '0;
            row_reg    <= '0;
            home_reg   <= '0;
            halted_reg <= 1'b0;
        end
        else if (accept && !drop)
        begin
            col_reg    <= col_next;
            row_reg    <= row_next;
            home_reg   <= home_next;
            halted_reg <= halted_next;
        end
    end

endmodule

// File: hw/rtl/gtr_queue.sv
// Short job queue between the front and back of the glyph text renderer.
// Depends on gtr_pkg for the job type and depth.
module gtr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gtr_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output gtr_pkg::job_t head_job
);

    localparam int DEPTH = gtr_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    gtr_pkg::job_t     entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/gtr_back.sv
// Back end of the glyph text renderer: walks each job's pixel mask one pixel a
// cycle while pix_ready allows, and forms framebuffer writes. Depends on gtr_pkg.
module gtr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  gtr_pkg::cfg_t      cfg,
    input  logic               head_valid,
    input  gtr_pkg::job_t      head_job,
    output logic               pop,
    output logic               pix_valid,
    input  logic               pix_ready,
    output gtr_pkg::pix_item_t pix_item
);

    localparam int SW    = gtr_pkg::SCREEN_W;
    localparam int NB    = gtr_pkg::GLYPH_BITS;
    localparam int POS_W = $clog2(NB);
    localparam int SUB_W = $clog2(gtr_pkg::GLYPH_SIZE);
    localparam int PROD_W = SW + gtr_pkg::CURSOR_W + 1;

    // Job being walked.
    logic          work_valid_reg;
    gtr_pkg::job_t work_reg;

    // Pixel select stage.
    logic                        a_valid_reg;
    logic [SW-1:0]               a_sx_reg, a_sy_reg;
    logic                        a_last_reg;
    logic [gtr_pkg::COLOR_W-1:0] a_color_reg;

    // Output register.
    logic               out_valid_reg;
    gtr_pkg::pix_item_t out_reg;

    logic [POS_W-1:0] hi;
    logic [POS_W-1:0] pos;
    logic [NB-1:0]    remain;
    logic             last;
    logic             b_ready, a_adv, fire;
    logic [PROD_W-1:0] index_full;

    always_comb
    begin
        hi = '0;
        for (int i = 0; i < NB; i++)
        begin
            if (work_reg.mask[i])
            begin
                hi = POS_W'(i);
            end
        end
        pos    = ~hi;
        remain = work_reg.mask & ~({{(NB-1){1'b0}}, 1'b1} << hi);
        last   = (remain == '0);
    end

    assign b_ready = !out_valid_reg || pix_ready;
    assign a_adv   = !a_valid_reg || b_ready;
    assign fire    = work_valid_reg && a_adv;
    assign pop     = head_valid && (!work_valid_reg || (fire && last));

    assign index_full = PROD_W'(a_sy_reg) * PROD_W'(cfg.scr_cols) + PROD_W'(a_sx_reg);

    assign pix_valid = out_valid_reg;
    assign pix_item  = out_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            work_reg <= head_job;
        end
        else if (fire)
        begin
            work_reg.mask <= remain;
        end
        if (a_adv)
        begin
            a_sx_reg    <= work_reg.sx0 + SW'(pos[SUB_W-1:0]);
            a_sy_reg    <= work_reg.sy0 + SW'(pos[POS_W-1:SUB_W]);
            a_last_reg  <= last;
            a_color_reg <= work_reg.color;
        end
        if (b_ready)
        begin
            out_reg.pixel_index <= index_full[gtr_pkg::INDEX_W-1:0];
            out_reg.pixel_value <= a_color_reg;
            out_reg.last_pixel  <= a_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            a_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                work_valid_reg <= 1'b1;
            end
            else if (fire && last)
            begin
                work_valid_reg <= 1'b0;
            end
            if (a_adv)
            begin
                a_valid_reg <= fire;
            end
            if (b_ready)
            begin
                out_valid_reg <= a_valid_reg;
            end
        end
    end

endmodule

// File: hw/rtl/glyph_text_renderer.sv
// Top level of the glyph text renderer: configuration registers and the
// front, queue and back parts. Depends on gtr_pkg, gtr_front, gtr_queue, gtr_back.
//
// The renderer takes one character item at a time, with its 8x8 glyph bitmap
// already looked up, and produces one framebuffer write item for every set
// glyph bit that lands inside both the session window and the screen, rows top
// to bottom and pixels left to right, with last_pixel marking the final write
// of each character. The front part accepts a character, updates the cursor
// and computes the clipped pixel mask; it takes a new character every cycle
// as long as the two-entry job queue has room. Characters that draw nothing
// (empty or fully clipped glyphs, or characters dropped after the cursor has
// run off the bottom of the window) never enter the queue. The back part walks
// each queued mask and emits one pixel write per cycle while pix_ready holds,
// so a character with N visible pixels gives N writes, from 1 up to 64; that
// one-write-per-cycle result channel sets the sustained rate. Between the head
// of the queue and the output a write passes the job register, the pixel
// select stage, the address multiply and the output register. The
// configuration port is always ready and must only be written while no
// character is in flight.
module glyph_text_renderer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             char_valid,
    output logic                             char_ready,
    input  gtr_pkg::char_item_t              char_item,
    output logic                             pix_valid,
    input  logic                             pix_ready,
    output gtr_pkg::pix_item_t               pix_item,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gtr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gtr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    gtr_pkg::cfg_t cfg_reg;
    logic          q_full;
    logic          push;
    gtr_pkg::job_t push_job;
    logic          pop;
    logic          head_valid;
    gtr_pkg::job_t head_job;

    // Writes to indexes past the register list are ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.win_x    <= '0;
            cfg_reg.win_y    <= '0;
            cfg_reg.win_w    <= 13'd1024;
            cfg_reg.win_h    <= 13'd768;
            cfg_reg.scr_cols <= 13'd1024;
            cfg_reg.scr_rows <= 13'd768;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gtr_pkg::REG_WIN_X:
                    cfg_reg.win_x <= cfg_data[gtr_pkg::COORD_W-1:0];
                gtr_pkg::REG_WIN_Y:
                    cfg_reg.win_y <= cfg_data[gtr_pkg::COORD_W-1:0];
                gtr_pkg::REG_WIN_W:
                    cfg_reg.win_w <= cfg_data;
                gtr_pkg::REG_WIN_H:
                    cfg_reg.win_h <= cfg_data;
                gtr_pkg::REG_SCR_COLS:
                    cfg_reg.scr_cols <= cfg_data;
                gtr_pkg::REG_SCR_ROWS:
                    cfg_reg.scr_rows <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    gtr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job)
    );

    gtr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    gtr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .pix_valid  (pix_valid),
        .pix_ready  (pix_ready),
        .pix_item   (pix_item)
    );

endmodule

// File: hw/rtl/gtr_checker.sv
// Port-level checks for the glyph text renderer, bound to the top level.
// Depends on gtr_pkg and glyph_text_renderer_macros.svh.
`include "glyph_text_renderer_macros.svh"

module gtr_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             char_valid,
    input logic                             char_ready,
    input gtr_pkg::char_item_t              char_item,
    input logic                             pix_valid,
    input logic                             pix_ready,
    input gtr_pkg::pix_item_t               pix_item,
    input logic                             cfg_valid,
    input logic                             cfg_ready
);

    // A stalled character item must hold still.
    `GTR_ASSERT_NEXT(a_char_hold, char_valid && !char_ready, char_valid && $stable(char_item), "character item changed while stalled")

    // A stalled write item must hold still.
    `GTR_ASSERT_NEXT(a_pix_hold, pix_valid && !pix_ready, pix_valid && $stable(pix_item), "pixel item changed while stalled")

    // Pixels of one character leave back to back once the first one is out.
    `GTR_ASSERT_NEXT(a_pix_burst, pix_valid && pix_ready && !pix_item.last_pixel, pix_valid, "gap inside a character's pixel burst")

    // Configuration writes are never refused.
    `GTR_ASSERT(a_cfg_ready, !cfg_valid || cfg_ready, "configuration port not ready")

endmodule

bind glyph_text_renderer gtr_checker u_gtr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pix_item   (pix_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
);
